// File: rtl/rlc_segmenting_packet_queue_core_assert.svh
// ----------------------------------------------------------------------------
// RLC segmenting packet queue: assertion macros
// Shared concurrent assertion forms used by the queue RTL.
// ----------------------------------------------------------------------------
`ifndef RLC_SEGMENTING_PACKET_QUEUE_CORE_ASSERT_SVH
`define RLC_SEGMENTING_PACKET_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define RLCQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlcq check failed");

// Next-cycle implication, checked outside of reset.
`define RLCQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlcq check failed");

`endif

// File: rtl/rlcq_pkg.sv
// ----------------------------------------------------------------------------
// RLC segmenting packet queue package
// Command, status, configuration and sequencer codes and default settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rlcq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int SIZE_BITS_DEF   = 16;

    localparam logic [31:0] MAX_DELAY_RST = 32'd100000;
    localparam logic [7:0]  OVERHEAD_RST  = 8'd8;

    typedef enum logic [1:0] {
        CMD_ENQUEUE  = 2'd0,
        CMD_TRANSMIT = 2'd1,
        CMD_DROP     = 2'd2,
        CMD_QUERY    = 2'd3
    } rlcq_cmd_t;

    typedef enum logic [2:0] {
        ST_ENQUEUED = 3'd0,
        ST_FULL     = 3'd1,
        ST_SENT     = 3'd2,
        ST_REFUSED  = 3'd3,
        ST_DROPPED  = 3'd4,
        ST_DONE     = 3'd5,
        ST_ANSWER   = 3'd6
    } rlcq_status_t;

    typedef enum logic {
        CFG_MAX_DELAY = 1'b0,
        CFG_OVERHEAD  = 1'b1
    } rlcq_cfg_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_OUT  = 2'd2
    } rlcq_state_t;

endpackage
`default_nettype wire

// File: rtl/rlcq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rlcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/rlc_segmenting_packet_queue_core.sv
// ----------------------------------------------------------------------------
// RLC segmenting packet queue core
// Packet FIFO with segmentation on transmit, age-based dropping and a
// byte-demand query, run by a small sequencer over one entry RAM.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_ready   cmd and its operands
// out       output     out_valid/out_ready status and segment description
// cfg       input      cfg_wr_en           cfg_index, cfg_wr_data
//
// Enqueue and transmit pass through accept (head entry read is issued),
// execute, and a result state that waits for out_ready.
// A drop check passes through execute and result once per dropped packet
// plus a final pair; a byte query stays in execute while it walks the
// packets in turn, as the single RAM read port reads one entry at a time.
// Reset clears pointers and counts and loads config defaults; entry RAM is kept.
// in_ready is low from acceptance until the last result of the request is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rlc_segmenting_packet_queue_core
    import rlcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int SIZE_BITS   = SIZE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration writes
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wr_data,
    // Request channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [15:0] packet_size,
    input  wire logic [15:0] packet_tag,
    input  wire logic [31:0] arrival_time,
    input  wire logic [15:0] available_bytes,
    input  wire logic [31:0] current_time,
    input  wire logic [21:0] byte_target,
    // Result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [15:0]      out_tag,
    output logic [15:0]      send_size,
    output logic [15:0]      start_byte,
    output logic [15:0]      end_byte,
    output logic [15:0]      fragment_index,
    output logic             is_segment,
    output logic             is_final_piece,
    output logic [20:0]      queued_bytes,
    output logic [5:0]       packet_count,
    output logic [21:0]      byte_answer,
    output logic             last
);

`include "rlc_segmenting_packet_queue_core_assert.svh"

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    // Grant comparison: remainder plus overhead against a 16-bit grant.
    localparam int CMP_W  = ((SIZE_BITS > 16) ? SIZE_BITS : 16) + 1;
    // Query accumulator: up to QUEUE_DEPTH times (size + overhead).
    localparam int ACC_W  = ((SIZE_BITS > 8) ? SIZE_BITS : 8) + CNT_W + 1;
    localparam int QRY_W  = (ACC_W > 22) ? ACC_W : 22;
    // Entry layout: {split, fragnum, offset, time, tag, size}.
    localparam int ENT_W  = 2 * SIZE_BITS + 16 + 32 + 16 + 1;
    localparam int O_TAG  = SIZE_BITS;
    localparam int O_TIME = O_TAG + 16;
    localparam int O_OFF  = O_TIME + 32;
    localparam int O_FRAG = O_OFF + SIZE_BITS;
    localparam int O_SPL  = O_FRAG + 16;

    function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] p);
        next_idx = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    rlcq_state_t state_reg, state_next;

    logic [31:0]          max_delay_reg;
    logic [7:0]           ovh_reg;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [20:0]          total_reg, total_next;
    logic [PTR_W-1:0]     walk_reg, walk_next;
    logic [CNT_W-1:0]     wcnt_reg, wcnt_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic                 count_mid;

    // Latched request
    rlcq_cmd_t            cmd_reg;
    logic [15:0]          size_reg;
    logic [15:0]          tag_reg;
    logic [31:0]          arr_reg;
    logic [15:0]          avail_reg;
    logic [31:0]          now_reg;
    logic [21:0]          target_reg;

    // Result register
    rlcq_status_t         r_status, res_status_reg;
    logic [15:0]          r_tag, res_tag_reg;
    logic [15:0]          r_send, res_send_reg;
    logic [15:0]          r_start, res_start_reg;
    logic [15:0]          r_end, res_end_reg;
    logic [15:0]          r_frag, res_frag_reg;
    logic                 r_seg, res_seg_reg;
    logic                 r_fin, res_fin_reg;
    logic [21:0]          r_answer, res_answer_reg;
    logic                 r_last, res_last_reg;
    logic [20:0]          res_total_reg;
    logic [CNT_W-1:0]     res_count_reg;
    logic                 exec_done;

    // Entry RAM
    logic                 ram_we;
    logic [PTR_W-1:0]     ram_waddr;
    logic [ENT_W-1:0]     ram_wdata;
    logic [PTR_W-1:0]     ram_raddr;
    logic [ENT_W-1:0]     ram_rdata;

    logic [SIZE_BITS-1:0] e_size;
    logic [15:0]          e_tag;
    logic [31:0]          e_time;
    logic [SIZE_BITS-1:0] e_off;
    logic [15:0]          e_frag;
    logic                 e_split;
    logic [SIZE_BITS-1:0] e_rem;
    logic [SIZE_BITS-1:0] enq_size;
    logic [SIZE_BITS-1:0] send_full;
    logic [SIZE_BITS-1:0] start_full;
    logic [15:0]          seg_len;
    logic [31:0]          age;
    logic                 too_old;
    logic [ACC_W-1:0]     acc_sum;

    assign e_size  = ram_rdata[SIZE_BITS-1:0];
    assign e_tag   = ram_rdata[O_TAG +: 16];
    assign e_time  = ram_rdata[O_TIME +: 32];
    assign e_off   = ram_rdata[O_OFF +: SIZE_BITS];
    assign e_frag  = ram_rdata[O_FRAG +: 16];
    assign e_split = ram_rdata[O_SPL];

    // Remainder never goes negative: an offset past the size leaves nothing.
    assign e_rem    = (e_off <= e_size) ? (e_size - e_off) : '0;
    assign enq_size = SIZE_BITS'(size_reg);
    assign seg_len  = avail_reg - 16'(ovh_reg);
    assign age      = now_reg - e_time;
    // A packet that arrives after the present time is never too old.
    assign too_old  = (now_reg >= e_time) && (age > max_delay_reg);
    assign acc_sum  = acc_reg + ACC_W'(e_rem) + ACC_W'(ovh_reg);

    // In execute the read runs ahead of the query walk entry; otherwise the head.
    assign ram_raddr = (state_reg == S_EXEC) ? next_idx(walk_reg) : head_reg;

    rlcq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = res_last_reg ? S_IDLE : S_EXEC;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Command execution and queue updates.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        total_next = total_reg;
        walk_next  = walk_reg;
        wcnt_next  = wcnt_reg;
        acc_next   = acc_reg;
        ram_we     = 1'b0;
        ram_waddr  = head_reg;
        ram_wdata  = ram_rdata;
        exec_done  = 1'b0;
        r_status   = ST_DONE;
        r_tag      = '0;
        r_send     = '0;
        r_start    = '0;
        r_end      = '0;
        r_frag     = '0;
        r_seg      = 1'b0;
        r_fin      = 1'b0;
        r_answer   = '0;
        r_last     = 1'b1;
        send_full  = '0;
        start_full = '0;

        if ((state_reg == S_IDLE) && in_valid)
        begin
            walk_next = head_reg;
            wcnt_next = '0;
            acc_next  = '0;
        end

        if (state_reg == S_EXEC)
        begin
            unique case (cmd_reg)
                CMD_ENQUEUE:
                begin
                    exec_done = 1'b1;
                    r_tag     = tag_reg;
                    if (count_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        r_status = ST_FULL;
                    end
                    else
                    begin
                        r_status   = ST_ENQUEUED;
                        ram_we     = 1'b1;
                        ram_waddr  = tail_reg;
                        ram_wdata  = {1'b0, 16'h0000, {SIZE_BITS{1'b0}}, arr_reg,
                                      tag_reg, enq_size};
                        tail_next  = next_idx(tail_reg);
                        count_next = count_reg + 1'b1;
                        total_next = total_reg + 21'(enq_size);
                    end
                end
                CMD_TRANSMIT:
                begin
                    exec_done = 1'b1;
                    if ((count_reg == '0) || (avail_reg <= 16'(ovh_reg)))
                    begin
                        r_status = ST_REFUSED;
                    end
                    else
                    begin
                        r_status   = ST_SENT;
                        r_tag      = e_tag;
                        r_frag     = e_frag;
                        start_full = e_split ? e_off : '0;
                        if ((CMP_W'(e_split ? e_rem : e_size) + CMP_W'(ovh_reg))
                            > CMP_W'(avail_reg))
                        begin
                            // Cut a segment and keep the rest at the head.
                            send_full  = SIZE_BITS'(seg_len);
                            r_seg      = 1'b1;
                            r_fin      = 1'b0;
                            ram_we     = 1'b1;
                            ram_waddr  = head_reg;
                            ram_wdata  = {1'b1, e_frag + 16'd1, SIZE_BITS'(e_off + send_full),
                                          e_time, e_tag, e_size};
                            total_next = total_reg - 21'(seg_len);
                            r_send     = seg_len;
                        end
                        else
                        begin
                            send_full  = e_split ? e_rem : e_size;
                            r_seg      = e_split;
                            r_fin      = 1'b1;
                            head_next  = next_idx(head_reg);
                            count_next = count_reg - 1'b1;
                            total_next = total_reg - 21'(e_rem);
                            r_send     = 16'(send_full);
                        end
                        r_start = 16'(start_full);
                        r_end   = 16'(start_full) + r_send - 16'd1;
                    end
                end
                CMD_DROP:
                begin
                    exec_done = 1'b1;
                    if ((count_reg != '0) && too_old)
                    begin
                        r_status   = ST_DROPPED;
                        r_tag      = e_tag;
                        r_last     = 1'b0;
                        head_next  = next_idx(head_reg);
                        count_next = count_reg - 1'b1;
                        total_next = total_reg - 21'(e_rem);
                    end
                    else
                    begin
                        r_status = ST_DONE;
                    end
                end
                CMD_QUERY:
                begin
                    r_status = ST_ANSWER;
                    if (wcnt_reg == count_reg)
                    begin
                        exec_done = 1'b1;
                        r_answer  = 22'(acc_reg);
                    end
                    else if (QRY_W'(acc_sum) >= QRY_W'(target_reg))
                    begin
                        exec_done = 1'b1;
                        r_answer  = 22'(acc_sum);
                    end
                    else
                    begin
                        acc_next  = acc_sum;
                        wcnt_next = wcnt_reg + 1'b1;
                        walk_next = next_idx(walk_reg);
                    end
                end
                default:
                begin
                    exec_done = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            max_delay_reg <= MAX_DELAY_RST;
            ovh_reg       <= OVERHEAD_RST;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            total_reg <= total_next;
            if (cfg_wr_en)
            begin
                unique case (rlcq_cfg_t'(cfg_index))
                    CFG_MAX_DELAY: max_delay_reg <= cfg_wr_data;
                    CFG_OVERHEAD:  ovh_reg       <= cfg_wr_data[7:0];
                    default:       ovh_reg       <= ovh_reg;
                endcase
            end
        end
    end

    // Payload registers: request operands, walk state and the result.
    always_ff @(posedge clk)
    begin
        walk_reg <= walk_next;
        wcnt_reg <= wcnt_next;
        acc_reg  <= acc_next;
        if ((state_reg == S_IDLE) && in_valid)
        begin
            cmd_reg    <= rlcq_cmd_t'(cmd);
            size_reg   <= packet_size;
            tag_reg    <= packet_tag;
            arr_reg    <= arrival_time;
            avail_reg  <= available_bytes;
            now_reg    <= current_time;
            target_reg <= byte_target;
        end
        if ((state_reg == S_EXEC) && exec_done)
        begin
            res_status_reg <= r_status;
            res_tag_reg    <= r_tag;
            res_send_reg   <= r_send;
            res_start_reg  <= r_start;
            res_end_reg    <= r_end;
            res_frag_reg   <= r_frag;
            res_seg_reg    <= r_seg;
            res_fin_reg    <= r_fin;
            res_answer_reg <= r_answer;
            res_last_reg   <= r_last;
            res_total_reg  <= total_next;
            res_count_reg  <= count_next;
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = (state_reg == S_OUT);
    assign status         = res_status_reg;
    assign out_tag        = res_tag_reg;
    assign send_size      = res_send_reg;
    assign start_byte     = res_start_reg;
    assign end_byte       = res_end_reg;
    assign fragment_index = res_frag_reg;
    assign is_segment     = res_seg_reg;
    assign is_final_piece = res_fin_reg;
    assign queued_bytes   = res_total_reg;
    assign packet_count   = 6'(res_count_reg);
    assign byte_answer    = res_answer_reg;
    assign last           = res_last_reg;

    // The queue holds packets but is not full.
    assign count_mid = (count_reg != '0) && (count_reg != CNT_W'(QUEUE_DEPTH));

    `RLCQ_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `RLCQ_ASSERT_NOW(a_ptr_match, clk, rst_n, (count_reg == '0), head_reg == tail_reg)
    `RLCQ_ASSERT_NOW(a_ptr_apart, clk, rst_n, count_mid, head_reg != tail_reg)
    `RLCQ_ASSERT_NOW(a_one_side, clk, rst_n, in_ready, !out_valid)
    `RLCQ_ASSERT_NEXT(a_drop_cont, clk, rst_n, out_valid && out_ready && !last, state_reg == S_EXEC)

endmodule
`default_nettype wire

// File: tb/tb_rlc_segmenting_packet_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RLC segmenting packet queue core testbench
// Drives enqueue, transmit, drop-check and byte-query requests into the queue,
// predicts every result with a behavioral model of the queue kept in this
// file, and compares each whole result under random idling and stalls.
// ----------------------------------------------------------------------------
module tb_rlc_segmenting_packet_queue_core;
    import rlcq_pkg::*;

    localparam int DEPTH     = 32;
    localparam int MAX_CYCLE = 2000000;

    // One result as it appears on the output ports.
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_tag;
        logic [15:0] send_size;
        logic [15:0] start_byte;
        logic [15:0] end_byte;
        logic [15:0] fragment_index;
        logic        is_segment;
        logic        is_final_piece;
        logic [20:0] queued_bytes;
        logic [5:0]  packet_count;
        logic [21:0] byte_answer;
        logic        last;
    } result_t;

    // One request with all of its operands.
    typedef struct packed {
        rlcq_cmd_t   cmd;
        logic [15:0] size;
        logic [15:0] tag;
        logic [31:0] arrival;
        logic [15:0] avail;
        logic [31:0] now;
        logic [21:0] target;
    } request_t;

    // A row of the directed table. When has_fixed is set, the first result
    // of the request must also equal the typed-in value.
    typedef struct {
        request_t req;
        bit       has_fixed;
        result_t  fixed;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [31:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [15:0] packet_size;
    logic [15:0] packet_tag;
    logic [31:0] arrival_time;
    logic [15:0] available_bytes;
    logic [31:0] current_time;
    logic [21:0] byte_target;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [15:0] out_tag;
    logic [15:0] send_size;
    logic [15:0] start_byte;
    logic [15:0] end_byte;
    logic [15:0] fragment_index;
    logic        is_segment;
    logic        is_final_piece;
    logic [20:0] queued_bytes;
    logic [5:0]  packet_count;
    logic [21:0] byte_answer;
    logic        last;

    rlc_segmenting_packet_queue_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .packet_size     (packet_size),
        .packet_tag      (packet_tag),
        .arrival_time    (arrival_time),
        .available_bytes (available_bytes),
        .current_time    (current_time),
        .byte_target     (byte_target),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .out_tag         (out_tag),
        .send_size       (send_size),
        .start_byte      (start_byte),
        .end_byte        (end_byte),
        .fragment_index  (fragment_index),
        .is_segment      (is_segment),
        .is_final_piece  (is_final_piece),
        .queued_bytes    (queued_bytes),
        .packet_count    (packet_count),
        .byte_answer     (byte_answer),
        .last            (last)
    );

    // 20 ns clock.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Queue model: a copy of the packet FIFO and the two registers.
    // ------------------------------------------------------------------
    logic [15:0] q_size   [DEPTH];
    logic [15:0] q_tag    [DEPTH];
    logic [31:0] q_time   [DEPTH];
    logic [15:0] q_offset [DEPTH];
    logic [15:0] q_frag   [DEPTH];
    logic        q_split  [DEPTH];
    int          q_head;
    int          q_tail;
    int          q_count;
    logic [20:0] q_bytes;
    logic [31:0] m_max_delay;
    logic [7:0]  m_overhead;

    result_t expected_results[$];

    // Run bookkeeping and the knobs that shape the stimulus.
    int        mismatches;
    int        cycles;
    bit        hold_off;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        items_sent;
    logic [31:0] clock_ticks;

    // Appends one predicted result at the tail of the expected list.
    function automatic void expect_result(result_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic logic [15:0] remaining_bytes(int i);
        return (q_offset[i] <= q_size[i]) ? q_size[i] - q_offset[i] : 16'd0;
    endfunction

    function automatic result_t base_result(rlcq_status_t st, logic [15:0] tag);
        result_t r;
        r = '0;
        r.status       = st;
        r.out_tag      = tag;
        r.queued_bytes = q_bytes;
        r.packet_count = q_count[5:0];
        return r;
    endfunction

    function automatic void remove_head();
        q_bytes = q_bytes - 21'(remaining_bytes(q_head));
        q_head  = (q_head + 1) % DEPTH;
        q_count--;
    endfunction

    // Works out all results of one request and queues them as expected.
    function automatic void predict_queue_results(request_t rq);
        result_t     r;
        logic [31:0] rem;
        logic [31:0] send;
        logic [15:0] start;
        logic [15:0] frag;
        logic [15:0] tag;
        logic        seg;
        logic [31:0] acc;
        int          p;
        case (rq.cmd)
            CMD_ENQUEUE:
            begin
                if (q_count >= DEPTH)
                begin
                    r = base_result(ST_FULL, rq.tag);
                end
                else
                begin
                    q_size[q_tail]   = rq.size;
                    q_tag[q_tail]    = rq.tag;
                    q_time[q_tail]   = rq.arrival;
                    q_offset[q_tail] = '0;
                    q_frag[q_tail]   = '0;
                    q_split[q_tail]  = 1'b0;
                    q_tail  = (q_tail + 1) % DEPTH;
                    q_count++;
                    q_bytes = q_bytes + 21'(rq.size);
                    r = base_result(ST_ENQUEUED, rq.tag);
                end
                r.last = 1'b1;
                expect_result(r);
            end
            CMD_TRANSMIT:
            begin
                if (q_count == 0 || rq.avail <= 16'(m_overhead))
                begin
                    r = base_result(ST_REFUSED, '0);
                end
                else
                begin
                    tag   = q_tag[q_head];
                    start = q_split[q_head] ? q_offset[q_head] : 16'd0;
                    rem   = q_split[q_head] ? 32'(remaining_bytes(q_head))
                                            : 32'(q_size[q_head]);
                    frag  = q_frag[q_head];
                    if (rem + 32'(m_overhead) > 32'(rq.avail))
                    begin
                        // The grant is too small: cut a segment off the head.
                        send = 32'(rq.avail) - 32'(m_overhead);
                        q_offset[q_head] = q_offset[q_head] + send[15:0];
                        q_split[q_head]  = 1'b1;
                        q_frag[q_head]   = frag + 16'd1;
                        q_bytes = q_bytes - send[20:0];
                        r = base_result(ST_SENT, tag);
                        r.is_segment     = 1'b1;
                        r.is_final_piece = 1'b0;
                    end
                    else
                    begin
                        send = rem;
                        seg  = q_split[q_head];
                        remove_head();
                        r = base_result(ST_SENT, tag);
                        r.is_segment     = seg;
                        r.is_final_piece = 1'b1;
                    end
                    r.send_size      = send[15:0];
                    r.start_byte     = start;
                    r.end_byte       = start + send[15:0] - 16'd1;
                    r.fragment_index = frag;
                end
                r.last = 1'b1;
                expect_result(r);
            end
            CMD_DROP:
            begin
                while (q_count > 0)
                begin
                    if (rq.now < q_time[q_head] ||
                        rq.now - q_time[q_head] <= m_max_delay)
                        break;
                    tag = q_tag[q_head];
                    remove_head();
                    expect_result(base_result(ST_DROPPED, tag));
                end
                r = base_result(ST_DONE, '0);
                r.last = 1'b1;
                expect_result(r);
            end
            default:
            begin
                acc = '0;
                p   = q_head;
                for (int k = 0; k < q_count; k++)
                begin
                    acc = acc + 32'(remaining_bytes(p)) + 32'(m_overhead);
                    if (acc >= 32'(rq.target))
                        break;
                    p = (p + 1) % DEPTH;
                end
                r = base_result(ST_ANSWER, '0);
                r.byte_answer = acc[21:0];
                r.last = 1'b1;
                expect_result(r);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking, sampled at the rising edge.
    // ------------------------------------------------------------------
    function automatic void report_mismatch(string what, result_t e, result_t a);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch (%s) at cycle %0d: expected %p, got %p",
                     what, cycles, e, a);
    endfunction

    always @(posedge clk)
    begin
        result_t act;
        result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            act = {status, out_tag, send_size, start_byte, end_byte, fragment_index,
                   is_segment, is_final_piece, queued_bytes, packet_count,
                   byte_answer, last};
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result", '0, act);
            end
            else
            begin
                exp_r = expected_results[0];
                expected_results.delete(0);
                if (act !== exp_r)
                    report_mismatch("predicted", exp_r, act);
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when asked.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
        cycles <= cycles + 1;

    always @(posedge clk)
    begin
        if (cycles >= MAX_CYCLE)
        begin
            $display("Run limit reached with %0d results outstanding",
                     expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Offers one request, with random idle cycles before it, and predicts
    // its results once the queue takes it. Valid stays high after the
    // handshake so that back-to-back requests need no gap; idle cycles and
    // drain() take it low.
    task automatic send_request(request_t rq, bit has_fixed, result_t fixed);
        int before_len;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        cmd             <= rq.cmd;
        packet_size     <= rq.size;
        packet_tag      <= rq.tag;
        arrival_time    <= rq.arrival;
        available_bytes <= rq.avail;
        current_time    <= rq.now;
        byte_target     <= rq.target;
        do
            @(posedge clk);
        while (!in_ready);
        before_len = expected_results.size();
        predict_queue_results(rq);
        if (has_fixed && expected_results[before_len] !== fixed)
            report_mismatch("table", fixed, expected_results[before_len]);
        items_sent++;
    endtask

    // Waits until every expected result has arrived, then lets a drop check
    // or byte query walking the whole queue finish before anything else.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2 * DEPTH + 10)
            @(posedge clk);
    endtask

    task automatic write_register(rlcq_cfg_t idx, logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MAX_DELAY)
            m_max_delay = value;
        else
            m_overhead = value[7:0];
        @(posedge clk);
    endtask

    function automatic request_t make_request(rlcq_cmd_t c, logic [15:0] size,
                                              logic [15:0] tag, logic [31:0] arr,
                                              logic [15:0] avail, logic [31:0] now,
                                              logic [21:0] target);
        request_t rq;
        rq.cmd     = c;
        rq.size    = size;
        rq.tag     = tag;
        rq.arrival = arr;
        rq.avail   = avail;
        rq.now     = now;
        rq.target  = target;
        return rq;
    endfunction

    // Random request, weighted toward useful traffic. Operands that the
    // command does not use still get random values so every bit toggles.
    function automatic request_t random_request();
        request_t rq;
        int       pick;
        rq = make_request(CMD_ENQUEUE, 16'($urandom), 16'($urandom), $urandom,
                          16'($urandom), $urandom, 22'($urandom));
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            rq.cmd = CMD_ENQUEUE;
            case ($urandom_range(3))
                0:       rq.size = 16'($urandom_range(40));
                1, 2:    rq.size = 16'($urandom_range(1, 600));
                default: rq.size = 16'($urandom);
            endcase
            // Arrival close to the running clock so age checks are meaningful.
            rq.arrival = clock_ticks - $urandom_range(3000);
            clock_ticks = clock_ticks + $urandom_range(200);
        end
        else if (pick < 72)
        begin
            rq.cmd = CMD_TRANSMIT;
            if ($urandom_range(4) == 0)
                rq.avail = 16'($urandom_range(0, 16'(m_overhead) + 1));
            else if ($urandom_range(4) == 0)
                rq.avail = 16'($urandom);
            else
                rq.avail = 16'(m_overhead) + 16'($urandom_range(1, 400));
        end
        else if (pick < 86)
        begin
            rq.cmd = CMD_DROP;
            if ($urandom_range(9) == 0)
                rq.now = $urandom;
            else
                rq.now = clock_ticks + $urandom_range(4000);
        end
        else
        begin
            rq.cmd = CMD_QUERY;
            if ($urandom_range(3) != 0)
                rq.target = 22'($urandom_range(3000));
        end
        return rq;
    endfunction

    task automatic random_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_request(random_request(), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Directed table: extremes, every command and the special cases.
    // ------------------------------------------------------------------
    row_t    table_rows[$];
    result_t fx;

    task automatic add_row(request_t rq, bit has_fixed, result_t f);
        row_t row;
        row.req       = rq;
        row.has_fixed = has_fixed;
        row.fixed     = f;
        table_rows.insert(table_rows.size(), row);
    endtask

    initial
    begin
        request_t rq;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = 1'b0;
        cfg_wr_data     = '0;
        in_valid        = 1'b0;
        cmd             = '0;
        packet_size     = '0;
        packet_tag      = '0;
        arrival_time    = '0;
        available_bytes = '0;
        current_time    = '0;
        byte_target     = '0;
        hold_off        = 1'b0;
        mismatches      = 0;
        cycles          = 0;
        items_sent      = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        clock_ticks     = 32'd10000;
        q_head  = 0;
        q_tail  = 0;
        q_count = 0;
        q_bytes = '0;
        m_max_delay = MAX_DELAY_RST;
        m_overhead  = OVERHEAD_RST;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue right after reset: transmit refused, query answers 0,
        // drop check reports done at once.
        fx = '0; fx.status = ST_REFUSED; fx.last = 1'b1;
        add_row(make_request(CMD_TRANSMIT, '0, '0, '0, 16'hFFFF, '0, '0), 1'b1, fx);
        fx = '0; fx.status = ST_ANSWER; fx.last = 1'b1;
        add_row(make_request(CMD_QUERY, '0, '0, '0, '0, '0, 22'h3FFFFF), 1'b1, fx);
        fx = '0; fx.status = ST_DONE; fx.last = 1'b1;
        add_row(make_request(CMD_DROP, '0, '0, '0, '0, 32'hFFFFFFFF, '0), 1'b1, fx);
        // Largest packet with all-ones tag into the empty queue.
        fx = '0; fx.status = ST_ENQUEUED; fx.out_tag = 16'hFFFF;
        fx.queued_bytes = 21'd65535; fx.packet_count = 6'd1; fx.last = 1'b1;
        add_row(make_request(CMD_ENQUEUE, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, '0, '0, '0),
                1'b1, fx);
        // Zero-size packet, then a small one.
        add_row(make_request(CMD_ENQUEUE, 16'd0, 16'h0001, 32'd0, '0, '0, '0), 1'b0, '0);
        add_row(make_request(CMD_ENQUEUE, 16'd100, 16'h5A5A, 32'd50, '0, '0, '0), 1'b0, '0);
        // Query with target 0 gives the head amount; a huge target walks all.
        add_row(make_request(CMD_QUERY, '0, '0, '0, '0, '0, 22'd0), 1'b0, '0);
        add_row(make_request(CMD_QUERY, '0, '0, '0, '0, '0, 22'h3FFFFF), 1'b0, '0);
        // Grant equal to the overhead is refused; one byte above cuts a segment.
        add_row(make_request(CMD_TRANSMIT, '0, '0, '0, 16'd8, '0, '0), 1'b0, '0);
        add_row(make_request(CMD_TRANSMIT, '0, '0, '0, 16'd9, '0, '0), 1'b0, '0);
        add_row(make_request(CMD_TRANSMIT, '0, '0, '0, 16'd1000, '0, '0), 1'b0, '0);
        // Full grant finishes the split packet, then the zero-size one.
        add_row(make_request(CMD_TRANSMIT, '0, '0, '0, 16'hFFFF, '0, '0), 1'b0, '0);
        add_row(make_request(CMD_TRANSMIT, '0, '0, '0, 16'hFFFF, '0, '0), 1'b0, '0);
        // Arrival after the present is kept; an old head is dropped.
        add_row(make_request(CMD_DROP, '0, '0, '0, '0, 32'd10, '0), 1'b0, '0);
        add_row(make_request(CMD_DROP, '0, '0, '0, '0, 32'd200000, '0), 1'b0, '0);
        add_row(make_request(CMD_QUERY, '0, '0, '0, '0, '0, 22'd1), 1'b0, '0);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (table_rows[i])
            send_request(table_rows[i].req, table_rows[i].has_fixed,
                         table_rows[i].fixed);
        drain();

        // Fill the queue to the top and past it while the receiver holds
        // off, so the input stalls; extra enqueues hit the full case.
        fork
            begin
                hold_off = 1'b1;
                repeat (300)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < DEPTH + 3; i++)
                begin
                    rq = make_request(CMD_ENQUEUE, 16'($urandom_range(1, 300)),
                                      16'($urandom), clock_ticks, '0, '0, '0);
                    send_request(rq, 1'b0, '0);
                end
            end
        join
        drain();
        // A full drop check gives the longest result burst.
        write_register(CFG_MAX_DELAY, 32'd0);
        send_request(make_request(CMD_DROP, '0, '0, '0, '0, clock_ticks + 32'd1, '0),
                     1'b0, '0);
        drain();

        // Random phases across register settings, extremes included.
        write_register(CFG_MAX_DELAY, 32'd2000);
        write_register(CFG_OVERHEAD, 32'd0);
        random_phase(77, 0, 0);
        drain();
        write_register(CFG_MAX_DELAY, 32'hFFFFFFFF);
        write_register(CFG_OVERHEAD, 32'd255);
        random_phase(77, 74, 0);
        drain();
        write_register(CFG_MAX_DELAY, 32'd500);
        write_register(CFG_OVERHEAD, 32'd20);
        random_phase(77, 0, 74);
        drain();
        write_register(CFG_MAX_DELAY, MAX_DELAY_RST);
        write_register(CFG_OVERHEAD, 32'(OVERHEAD_RST));
        random_phase(77, 17, 17);

        drain();
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatches, expected_results.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
